// ----- rtl/ffa_pkg.sv -----
// Shared constants, result codes and controller/datapath command types
// for the first-fit heap allocator. No dependencies.
package ffa_pkg;

  localparam int unsigned ARENA_BYTES  = 262144;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned GRAIN_BYTES  = 16;
  localparam int unsigned GRAIN_LG     = $clog2(GRAIN_BYTES);
  localparam int unsigned SLOT_COUNT   = ARENA_BYTES / GRAIN_BYTES;
  localparam int unsigned SLOT_W       = $clog2(SLOT_COUNT);

  // Field widths of the request and result
  localparam int unsigned REQ_W    = 19;
  localparam int unsigned OFF_W    = 18;
  localparam int unsigned STATUS_W = 2;

  // Internal widths
  localparam int unsigned SIZE_W  = 18;
  localparam int unsigned ENTRY_W = SIZE_W + 1;
  localparam int unsigned WALK_W  = OFF_W + 1;
  localparam int unsigned NEED_W  = REQ_W + 1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;

  typedef struct packed {
    logic                load;
    logic                rd_cur;
    logic                rd_nxt;
    logic                cap_cur;
    logic                cap_nxt;
    logic                advance;
    logic                wr_split;
    logic                wr_alloc;
    logic                wr_free;
    logic                set_res;
    logic                res_ptr;
    logic [STATUS_W-1:0] res_code;
    logic                push;
  } ffa_cmd_t;

  typedef struct packed {
    logic op_free;
    logic rel_null;
    logic at_end;
    logic alloc_hit;
    logic split_ok;
    logic free_hit;
    logic nxt_in;
  } ffa_sts_t;

endpackage

// ----- rtl/ffa_req_if.sv -----
// Request channel of the first-fit heap allocator: valid/ready plus payload.
// Depends on ffa_pkg.
interface ffa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [ffa_pkg::REQ_W-1:0]   request_size;
  logic [ffa_pkg::OFF_W-1:0]   release_offset;

  modport source (output valid, op, request_size, release_offset, input ready);
  modport sink   (input valid, op, request_size, release_offset, output ready);
endinterface

// ----- rtl/ffa_rsp_if.sv -----
// Result channel of the first-fit heap allocator: valid/ready plus payload.
// Depends on ffa_pkg.
interface ffa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffa_pkg::OFF_W-1:0]    payload_offset;
  logic [ffa_pkg::STATUS_W-1:0] status;

  modport source (output valid, payload_offset, status, input ready);
  modport sink   (input valid, payload_offset, status, output ready);
endinterface

// ----- rtl/ffa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ffa_ctrl.sv -----
// Controller state machine of the first-fit heap allocator: walks the
// block chain by commanding the datapath. Depends on ffa_pkg.
module ffa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ffa_pkg::ffa_sts_t sts_i,
  output ffa_pkg::ffa_cmd_t cmd_o
);
  import ffa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_EV    = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_WSPL  = 4'd4;
  localparam logic [3:0] S_WCUR  = 4'd5;
  localparam logic [3:0] S_EVN   = 4'd6;
  localparam logic [3:0] S_WFREE = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  ffa_cmd_t   cmd;

  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.op_free && sts_i.rel_null) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_DONE;
          state_d      = S_OUT;
        end else if (sts_i.at_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = sts_i.op_free ? ST_BAD_ADDR : ST_NO_ROOM;
          state_d      = S_OUT;
        end else begin
          cmd.rd_cur = 1'b1;
          state_d    = S_EV;
        end
      end
      S_EV: begin
        cmd.cap_cur = 1'b1;
        state_d     = S_DEC;
      end
      S_DEC: begin
        if (!sts_i.op_free && sts_i.alloc_hit) begin
          state_d = sts_i.split_ok ? S_WSPL : S_WCUR;
        end else if (sts_i.op_free && sts_i.free_hit) begin
          if (sts_i.nxt_in) begin
            cmd.rd_nxt = 1'b1;
            state_d    = S_EVN;
          end else begin
            state_d = S_WFREE;
          end
        end else begin
          cmd.advance = 1'b1;
          state_d     = S_CHK;
        end
      end
      S_WSPL: begin
        cmd.wr_split = 1'b1;
        state_d      = S_WCUR;
      end
      S_WCUR: begin
        cmd.wr_alloc = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_ptr  = 1'b1;
        cmd.res_code = ST_DONE;
        state_d      = S_OUT;
      end
      S_EVN: begin
        cmd.cap_nxt = 1'b1;
        state_d     = S_WFREE;
      end
      S_WFREE: begin
        cmd.wr_free  = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_DONE;
        state_d      = S_OUT;
      end
      S_OUT: begin
        // hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd.push = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  a_accept_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CHK))
    else $error("accepted request did not start a walk");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result raised outside of the hand-over state");

  a_one_ram_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.rd_cur, cmd.rd_nxt, cmd.wr_split, cmd.wr_alloc, cmd.wr_free}))
    else $error("more than one RAM access in a cycle");

  a_split_then_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WSPL) |=> (state_q == S_WCUR))
    else $error("split write not followed by header update");

endmodule

// ----- rtl/ffa_dpath.sv -----
// Datapath of the first-fit heap allocator: walk registers, size math,
// block header RAM and result registers. Depends on ffa_pkg and ffa_ram.
module ffa_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffa_pkg::ffa_cmd_t            cmd_i,
  input  logic                         op_i,
  input  logic [ffa_pkg::REQ_W-1:0]    request_size_i,
  input  logic [ffa_pkg::OFF_W-1:0]    release_offset_i,
  output ffa_pkg::ffa_sts_t            sts_o,
  output logic [ffa_pkg::OFF_W-1:0]    payload_offset_o,
  output logic [ffa_pkg::STATUS_W-1:0] status_o
);
  import ffa_pkg::*;

  logic                op_q;
  logic [NEED_W-1:0]   need_q;
  logic [OFF_W-1:0]    rel_q;
  logic [WALK_W-1:0]   off_q;
  logic [SIZE_W-1:0]   have_q;
  logic                free_q;
  logic [SIZE_W-1:0]   nsize_q;
  logic                nfree_q;
  logic [SLOT_W-1:0]   rd_slot_q;
  logic                e0_wr_q;
  logic [OFF_W-1:0]    pend_off_q;
  logic [STATUS_W-1:0] pend_code_q;
  logic [OFF_W-1:0]    out_off_q;
  logic [STATUS_W-1:0] out_code_q;

  logic [NEED_W-1:0]  need_d;
  logic [WALK_W-1:0]  nx;
  logic [NEED_W:0]    split_off;
  logic [NEED_W:0]    need_plus;
  logic               split_ok;
  logic               merge;
  logic [SIZE_W-1:0]  rem_size;
  logic [SIZE_W-1:0]  merged_size;
  logic [WALK_W-1:0]  payload_ptr;

  logic               ram_we, ram_re;
  logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata, entry_view;

  // round the request up to whole grains
  assign need_d = (NEED_W'(request_size_i) + NEED_W'(GRAIN_BYTES - 1))
                & ~NEED_W'(GRAIN_BYTES - 1);

  assign nx          = off_q + WALK_W'(HEADER_BYTES) + WALK_W'(have_q);
  assign payload_ptr = off_q + WALK_W'(HEADER_BYTES);
  assign split_off   = (NEED_W+1)'(off_q) + (NEED_W+1)'(HEADER_BYTES) + (NEED_W+1)'(need_q);
  assign need_plus   = (NEED_W+1)'(need_q) + (NEED_W+1)'(HEADER_BYTES + GRAIN_BYTES);
  assign split_ok    = ((NEED_W+1)'(have_q) >= need_plus);
  assign rem_size    = have_q - need_q[SIZE_W-1:0] - SIZE_W'(HEADER_BYTES);
  assign merge       = nfree_q && sts_o.nxt_in;
  assign merged_size = have_q + SIZE_W'(HEADER_BYTES) + nsize_q;

  assign sts_o.op_free   = op_q;
  assign sts_o.rel_null  = (rel_q == '0);
  assign sts_o.at_end    = (off_q >= WALK_W'(ARENA_BYTES));
  assign sts_o.alloc_hit = free_q && (NEED_W'(have_q) >= need_q);
  assign sts_o.split_ok  = split_ok;
  assign sts_o.free_hit  = (payload_ptr == WALK_W'(rel_q));
  assign sts_o.nxt_in    = (nx < WALK_W'(ARENA_BYTES));

  // header RAM: {free, size} per granule
  assign ram_re    = cmd_i.rd_cur || cmd_i.rd_nxt;
  assign ram_raddr = cmd_i.rd_nxt ? nx[SLOT_W+GRAIN_LG-1:GRAIN_LG]
                                  : off_q[SLOT_W+GRAIN_LG-1:GRAIN_LG];
  assign ram_we    = cmd_i.wr_split || cmd_i.wr_alloc || cmd_i.wr_free;
  assign ram_waddr = cmd_i.wr_split ? split_off[SLOT_W+GRAIN_LG-1:GRAIN_LG]
                                    : off_q[SLOT_W+GRAIN_LG-1:GRAIN_LG];

  always_comb begin
    priority if (cmd_i.wr_split) begin
      ram_wdata = {1'b1, rem_size};
    end else if (cmd_i.wr_alloc) begin
      ram_wdata = {1'b0, split_ok ? need_q[SIZE_W-1:0] : have_q};
    end else begin
      ram_wdata = {1'b1, merge ? merged_size : have_q};
    end
  end

  ffa_ram #(
    .Width (ENTRY_W),
    .Depth (SLOT_COUNT)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the first header reads as one free block over the arena until written
  assign entry_view = (rd_slot_q == '0 && !e0_wr_q)
                    ? {1'b1, SIZE_W'(ARENA_BYTES - HEADER_BYTES)} : ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_wr_q <= 1'b0;
    end else if (ram_we && ram_waddr == '0) begin
      e0_wr_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      need_q <= need_d;
      rel_q  <= release_offset_i;
      off_q  <= '0;
    end else if (cmd_i.advance) begin
      off_q <= nx;
    end
    if (ram_re) begin
      rd_slot_q <= ram_raddr;
    end
    if (cmd_i.cap_cur) begin
      {free_q, have_q} <= entry_view;
      nfree_q          <= 1'b0;
    end
    if (cmd_i.cap_nxt) begin
      {nfree_q, nsize_q} <= entry_view;
    end
    if (cmd_i.set_res) begin
      pend_off_q  <= cmd_i.res_ptr ? payload_ptr[OFF_W-1:0] : '0;
      pend_code_q <= cmd_i.res_code;
    end
    if (cmd_i.push) begin
      out_off_q  <= pend_off_q;
      out_code_q <= pend_code_q;
    end
  end

  assign payload_offset_o = out_off_q;
  assign status_o         = out_code_q;

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// First-fit heap allocator over a 256 KiB arena of address-ordered blocks,
// each with a 16-byte header (payload size and free mark). An allocate
// request rounds its size up to 16 bytes, walks the chain from offset 0,
// takes the first free block that fits, splits off any remainder that can
// hold a header plus 16 bytes, and returns the payload offset, or status
// out_of_heap with offset 0. A free request marks its block free and merges
// it with the next block when that one is free; offset 0 is a null free and
// reports done, an offset that starts no block reports bad_address. Exactly
// one result per request. Requests are handled one at a time. The walk reads
// each block header from a registered header RAM of 16384 entries: issue the
// read, capture the entry, decide. A null free reads no header. An allocate
// that splits writes the split header before its own, and a free whose block
// has a successor reads that header as well. A result that cannot yet enter
// the output register holds the walk until it can. A new request is taken
// while a result still waits in the output register. The header RAM needs
// no clearing pass after reset.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if, ffa_ctrl and ffa_dpath.
module first_fit_heap_allocator (
  input  logic         clk_i,
  input  logic         rst_ni,
  ffa_req_if.sink      req_i,
  ffa_rsp_if.source    rsp_o
);
  import ffa_pkg::*;

  ffa_cmd_t cmd;
  ffa_sts_t sts;

  // sequence the walk: one header fetch, capture and decision per block
  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // hold the walk position, the header RAM and the result registers
  ffa_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .op_i             (req_i.op),
    .request_size_i   (req_i.request_size),
    .release_offset_i (req_i.release_offset),
    .sts_o            (sts),
    .payload_offset_o (rsp_o.payload_offset),
    .status_o         (rsp_o.status)
  );

endmodule

// ----- test/first_fit_heap_allocator_tb.sv -----
// Self-checking testbench for first_fit_heap_allocator: directed corner requests, then
// random allocate/free traffic against a shadow copy of the block chain.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if and the allocator RTL.
module first_fit_heap_allocator_tb;
  import ffa_pkg::*;

  // Operation codes of the request's op field
  localparam bit OP_ALLOC = 1'b0;
  localparam bit OP_FREE  = 1'b1;

  localparam int unsigned RANDOM_ITEMS = 1930;
  // Sweep the chain back to one block once it grows past this many blocks,
  // which keeps every walk short.
  localparam int unsigned BLOCK_CAP    = 40;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 3 * (BLOCK_CAP + 8) + 16;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  typedef struct packed {
    logic [OFF_W-1:0]    offset;
    logic [STATUS_W-1:0] status;
  } reply_t;

  typedef enum int unsigned {
    SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_SPARSE, SINK_PERIODIC
  } sink_mode_e;

  // Shadow of the arena: block headers indexed by granule, plus the replies
  // still owed by the block in request order.
  class arena_shadow;
    int unsigned blk_size [SLOT_COUNT];
    bit          blk_free [SLOT_COUNT];
    int unsigned heads[$];
    reply_t      due_replies[$];
    int unsigned errors;

    function new();
      foreach (blk_size[i]) begin
        blk_size[i] = 0;
        blk_free[i] = 1'b0;
      end
      blk_size[0] = ARENA_BYTES - HEADER_BYTES;
      blk_free[0] = 1'b1;
      errors = 0;
    endfunction

    function int unsigned slot_of(int unsigned off);
      return (off / GRAIN_BYTES) % SLOT_COUNT;
    endfunction

    function void refresh_heads();
      int unsigned off;
      heads.delete();
      off = 0;
      while (off < ARENA_BYTES) begin
        heads.push_back(off);
        off = off + HEADER_BYTES + blk_size[slot_of(off)];
      end
    endfunction

    function int unsigned largest_free();
      int unsigned best;
      best = 0;
      foreach (heads[i])
        if (blk_free[slot_of(heads[i])] && blk_size[slot_of(heads[i])] > best)
          best = blk_size[slot_of(heads[i])];
      return best;
    endfunction

    // First fit: round up to a grain, split when the rest holds header + grain.
    function reply_t grant(int unsigned req);
      int unsigned need, off, s, have, ns;
      reply_t r;
      need = (req + GRAIN_BYTES - 1) & ~(GRAIN_BYTES - 1);
      r.offset = '0;
      r.status = ST_NO_ROOM;
      off = 0;
      while (off < ARENA_BYTES) begin
        s = slot_of(off);
        have = blk_size[s];
        if (blk_free[s] && have >= need) begin
          if (have >= need + HEADER_BYTES + GRAIN_BYTES) begin
            ns = slot_of(off + HEADER_BYTES + need);
            blk_size[ns] = have - need - HEADER_BYTES;
            blk_free[ns] = 1'b1;
            blk_size[s]  = need;
          end
          blk_free[s] = 1'b0;
          r.offset = OFF_W'(off + HEADER_BYTES);
          r.status = ST_DONE;
          return r;
        end
        off = off + HEADER_BYTES + have;
      end
      return r;
    endfunction

    // Mark free and merge forward; null is a no-op, a non-payload offset is bad.
    function logic [STATUS_W-1:0] give_back(int unsigned rel);
      int unsigned off, s, nx;
      if (rel == 0) return ST_DONE;
      off = 0;
      while (off < ARENA_BYTES) begin
        s  = slot_of(off);
        nx = off + HEADER_BYTES + blk_size[s];
        if (off + HEADER_BYTES == rel) begin
          blk_free[s] = 1'b1;
          if (nx < ARENA_BYTES && blk_free[slot_of(nx)])
            blk_size[s] += HEADER_BYTES + blk_size[slot_of(nx)];
          return ST_DONE;
        end
        off = nx;
      end
      return ST_BAD_ADDR;
    endfunction

    function void take_request(bit op, logic [REQ_W-1:0] size, logic [OFF_W-1:0] rel);
      reply_t r;
      if (op == OP_ALLOC) begin
        r = grant(int'(size));
      end else begin
        r.offset = '0;
        r.status = give_back(int'(rel));
      end
      due_replies.push_back(r);
    endfunction

    function void match_reply(logic [OFF_W-1:0] offset, logic [STATUS_W-1:0] status);
      reply_t want;
      if (due_replies.size() == 0) begin
        $display("%0t: reply with none pending: payload_offset %0d status %0d",
                 $time, offset, status);
        errors++;
        return;
      end
      want = due_replies.pop_front();
      if (offset !== want.offset) begin
        $display("%0t: payload_offset expected %0d, got %0d", $time, want.offset, offset);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   hold_off;

  arena_shadow sb;
  int unsigned sweep_list[$];

  ffa_req_if req_bus ();
  ffa_rsp_if rsp_bus ();

  first_fit_heap_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offer one request from a falling edge; hold it until accepted, then note
  // it in the shadow and return on the next falling edge with valid still high.
  task automatic offer(input bit op, input int unsigned size, input int unsigned rel);
    req_bus.op             = op;
    req_bus.request_size   = size[REQ_W-1:0];
    req_bus.release_offset = rel[OFF_W-1:0];
    req_bus.valid          = 1'b1;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    sb.take_request(op, size[REQ_W-1:0], rel[OFF_W-1:0]);
    @(negedge clk_i);
  endtask

  // Mostly small sizes so the chain stays short; a few huge ones to run
  // out of heap, including values past the arena with the top bit set.
  function automatic int unsigned random_size();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return $urandom_range(0, 256);
    if (pick < 17) return $urandom_range(257, 4096);
    if (pick < 19) return $urandom_range(4097, 65536);
    return $urandom_range(65537, 2**REQ_W - 1);
  endfunction

  task automatic pick_request(output bit op, output int unsigned size,
                              output int unsigned rel);
    int unsigned roll;
    int unsigned live[$];
    // Fill the field the op ignores with noise so all its bits toggle.
    size = $urandom_range(0, 2**REQ_W - 1);
    rel  = $urandom_range(0, 2**OFF_W - 1);
    sb.refresh_heads();
    // Start a sweep: free every block from the highest down, so each free
    // merges forward into what was swept before and one block remains.
    if (sweep_list.size() == 0 && sb.heads.size() > BLOCK_CAP)
      foreach (sb.heads[i]) sweep_list.push_front(sb.heads[i] + HEADER_BYTES);
    if (sweep_list.size() != 0) begin
      op  = OP_FREE;
      rel = sweep_list.pop_front();
      return;
    end
    foreach (sb.heads[i])
      if (!sb.blk_free[sb.slot_of(sb.heads[i])]) live.push_back(sb.heads[i] + HEADER_BYTES);
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      op   = OP_ALLOC;
      size = random_size();
    end else if (roll < 48) begin
      // exact fit of the largest free block: no split
      op   = OP_ALLOC;
      size = sb.largest_free();
    end else if (roll < 80 && live.size() != 0) begin
      op  = OP_FREE;
      rel = live[$urandom_range(0, live.size() - 1)];
    end else if (roll < 85) begin
      // any block, free ones included: double free with merge attempt
      op  = OP_FREE;
      rel = sb.heads[$urandom_range(0, sb.heads.size() - 1)] + HEADER_BYTES;
    end else if (roll < 88) begin
      op  = OP_FREE;
      rel = 0;
    end else if (roll < 94) begin
      // inside a payload, off the grain
      op  = OP_FREE;
      rel = sb.heads[$urandom_range(0, sb.heads.size() - 1)] + HEADER_BYTES
            + $urandom_range(1, GRAIN_BYTES - 1);
    end else if (roll < 97) begin
      op = OP_FREE;
    end else begin
      // header offset instead of payload offset
      op  = OP_FREE;
      rel = sb.heads[$urandom_range(0, sb.heads.size() - 1)];
    end
  endtask

  // Corner cases from reset; the offsets follow from the four leading allocs:
  // blocks at 0 (0 B), 16 (16 B), 48 (16 B), 80 (32 B), rest free at 128.
  task automatic directed_requests();
    offer(OP_ALLOC, 0, 0);
    offer(OP_ALLOC, 1, 2**OFF_W - 1);
    offer(OP_ALLOC, GRAIN_BYTES, 0);
    offer(OP_ALLOC, GRAIN_BYTES + 1, 0);
    offer(OP_FREE, 2**REQ_W - 1, 0);          // null free
    offer(OP_FREE, 0, 40);                    // off the grain
    offer(OP_FREE, 0, 2**OFF_W - 1);          // beyond any block
    offer(OP_FREE, 0, 32);                    // next block busy: no merge
    offer(OP_FREE, 0, 32);                    // free of a free block
    offer(OP_FREE, 0, 16);                    // merges with the block at 16
    offer(OP_FREE, 0, 96);                    // merges with the tail
    offer(OP_FREE, 0, 64);
    offer(OP_FREE, 0, 16);                    // back to one block
    offer(OP_ALLOC, 2**REQ_W - 1, 0);         // out of heap
    offer(OP_ALLOC, ARENA_BYTES, 0);          // out of heap
    offer(OP_ALLOC, ARENA_BYTES - HEADER_BYTES, 0);
    offer(OP_ALLOC, 0, 0);                    // nothing free at all
    offer(OP_FREE, 0, HEADER_BYTES);
    offer(OP_ALLOC, ARENA_BYTES - HEADER_BYTES + 1, 0);
    offer(OP_ALLOC, ARENA_BYTES - 3 * HEADER_BYTES + 1, 0); // remainder too small
    offer(OP_FREE, 0, HEADER_BYTES);
    offer(OP_ALLOC, ARENA_BYTES - 3 * HEADER_BYTES, 0);     // split leaves one grain
    offer(OP_ALLOC, GRAIN_BYTES, 0);
    offer(OP_FREE, 0, ARENA_BYTES - GRAIN_BYTES);           // last block: nothing follows
    offer(OP_FREE, 0, HEADER_BYTES);
  endtask

  // Request side: directed list, then random bursts with random gaps.
  initial begin : request_source
    int unsigned burst, gap, sent, size, rel;
    bit op, held, paused;
    sb = new();
    rst_ni                 = 1'b0;
    hold_off               = 1'b0;
    req_bus.valid          = 1'b0;
    req_bus.op             = OP_ALLOC;
    req_bus.request_size   = '0;
    req_bus.release_offset = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed_requests();

    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        pick_request(op, size, rel);
        offer(op, size, rel);
        sent++;
        // stall the reply side for a long stretch while requests keep coming
        if (!held && sent >= 700) begin
          hold_off = 1'b1;
          held     = 1'b1;
        end
      end
      // a quarter of the bursts, and some others by chance, run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (!paused && sent >= 1200) begin
        // drain: hold off until every reply is back
        req_bus.valid = 1'b0;
        while (sb.due_replies.size() != 0) @(negedge clk_i);
        paused = 1'b1;
      end else if (gap != 0) begin
        req_bus.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end

    req_bus.valid = 1'b0;
    while (sb.due_replies.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Reply side: ready follows a mode that is picked anew at random, with a
  // single long hold-off when the request side asks for one.
  initial begin : reply_sink
    int unsigned phase;
    sink_mode_e mode;
    rsp_bus.ready = 1'b0;
    phase = 0;
    mode  = SINK_OPEN;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        rsp_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end
      if (phase % 256 == 0) mode = sink_mode_e'($urandom_range(0, 4));
      phase++;
      case (mode)
        SINK_OPEN:     rsp_bus.ready = 1'b1;
        SINK_COIN:     rsp_bus.ready = ($urandom_range(0, 1) == 1);
        SINK_MOSTLY:   rsp_bus.ready = ($urandom_range(0, 9) != 0);
        SINK_SPARSE:   rsp_bus.ready = ($urandom_range(0, 4) == 0);
        SINK_PERIODIC: rsp_bus.ready = ((phase % 5) < 2);
        default:       rsp_bus.ready = 1'b1;
      endcase
    end
  end

  // Check every reply taken at a rising edge against the oldest pending one.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
      sb.match_reply(rsp_bus.payload_offset, rsp_bus.status);
  end

  // Stop a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
